// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL core (arp_cache_table_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold too.
`define ACT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arp cache table assertion failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ACT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arp cache table assertion failed");
`else
`define ACT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ACT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/act_pkg.sv -----
package act_pkg;

   // table size and derived index width
   localparam int ENTRY_COUNT = 8;
   localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   // field widths
   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int TIME_W = 32;
   localparam int ROW_W  = IP_W + MAC_W + TIME_W;

   localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd60000;

   // action codes
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   // entry kinds
   localparam logic [1:0] KIND_UNUSED  = 2'd0;
   localparam logic [1:0] KIND_STATIC  = 2'd1;
   localparam logic [1:0] KIND_DYNAMIC = 2'd2;

   // result status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;
   localparam logic [1:0] STS_MISS    = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic             load;    // request transfer, latch the item
      logic             scan;    // issue a table read at addr
      logic [IDX_W-1:0] addr;
      logic             decide;  // update the table and load the result
   } act_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic down;       // current item scans from the top entry downward
      logic out_ready;  // result register can take a new result
   } act_sts_type;

endpackage

// ----- hdl/act_ram.sv -----
module act_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/act_ctrl.sv -----
module act_ctrl
   import act_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  act_sts_type sts,
   output act_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_DECIDE = 4'b1000
   } act_state_type;

   act_state_type    state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   // next state and scan counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // commands to the datapath
   assign req_tready = (state_ff == S_IDLE);
   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.scan   = (state_ff == S_SCAN);
   assign cmd.addr   = sts.down ? (LAST_IDX - cnt_ff) : cnt_ff;
   assign cmd.decide = (state_ff == S_DECIDE) && sts.out_ready;

endmodule

// ----- hdl/act_dpath.sv -----
module act_dpath
   import act_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  act_cmd_type       cmd,
   output act_sts_type       sts,
   input  logic [1:0]        req_action,
   input  logic              req_make_static,
   input  logic [IP_W-1:0]   req_ip,
   input  logic [MAC_W-1:0]  req_mac,
   input  logic [TIME_W-1:0] req_now,
   input  logic              csr_wr_en,
   input  logic [TIME_W-1:0] csr_wr_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [MAC_W-1:0]  rsp_mac
);

   // latched request
   logic [1:0]        op_ff;
   logic [1:0]        kind_req_ff;
   logic [IP_W-1:0]   ip_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic [TIME_W-1:0] now_ff;

   logic [TIME_W-1:0] period_ff;

   // table: kinds in flops (reset to unused), rows in RAM
   logic [1:0]        kind_ff [ENTRY_COUNT];
   logic              kind_we;
   logic [IDX_W-1:0]  kind_widx;
   logic [1:0]        kind_wval;
   logic              row_we;
   logic [IDX_W-1:0]  row_widx;
   logic [ROW_W-1:0]  row_rdata;

   // probe stage, aligned with the RAM read data
   logic              probe_vld_ff;
   logic [IDX_W-1:0]  probe_idx_ff;
   logic [1:0]        probe_kind_ff;
   logic [IP_W-1:0]   probe_ip;
   logic [MAC_W-1:0]  probe_mac;
   logic [TIME_W-1:0] probe_time;
   logic              probe_used;
   logic              probe_ip_hit;
   logic              hit;
   logic              old_cand;
   logic              free_cand;

   // scan results
   logic              have_match_ff;
   logic [IDX_W-1:0]  match_idx_ff;
   logic [1:0]        match_kind_ff;
   logic [MAC_W-1:0]  match_mac_ff;
   logic [TIME_W-1:0] match_time_ff;
   logic              have_free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              have_old_ff;
   logic [IDX_W-1:0]  old_idx_ff;
   logic [TIME_W-1:0] old_time_ff;

   // decision
   logic [TIME_W-1:0] age;
   logic              fresh;
   logic [1:0]        res_status;
   logic [MAC_W-1:0]  res_mac;

   // result register
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [MAC_W-1:0]  rsp_mac_ff;

   // latch the item on its transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_action;
         kind_req_ff <= req_make_static ? KIND_STATIC : KIND_DYNAMIC;
         ip_ff       <= req_ip;
         mac_ff      <= req_mac;
         now_ff      <= req_now;
      end
   end

   // validity period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   // kind array
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            kind_ff[i] <= KIND_UNUSED;
         end
      end else if (kind_we) begin
         kind_ff[kind_widx] <= kind_wval;
      end
   end

   act_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRY_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_widx),
      .wr_data ({now_ff, mac_ff, ip_ff}),
      .rd_addr (cmd.addr),
      .rd_data (row_rdata)
   );

   // probe stage: kind and index are registered alongside the RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_vld_ff <= 1'b0;
      end else begin
         probe_vld_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      probe_idx_ff  <= cmd.addr;
      probe_kind_ff <= kind_ff[cmd.addr];
   end

   assign probe_ip     = row_rdata[IP_W-1:0];
   assign probe_mac    = row_rdata[IP_W+MAC_W-1:IP_W];
   assign probe_time   = row_rdata[ROW_W-1:IP_W+MAC_W];
   assign probe_used   = (probe_kind_ff != KIND_UNUSED);
   assign probe_ip_hit = (probe_ip == ip_ff);

   // classify the probed entry for the current action
   always_comb begin
      hit       = 1'b0;
      old_cand  = 1'b0;
      free_cand = 1'b0;
      case (op_ff)
         ACT_ADD: begin
            hit = probe_used && probe_ip_hit &&
                  (probe_kind_ff == kind_req_ff || probe_kind_ff == KIND_DYNAMIC);
            old_cand  = !hit && (probe_kind_ff == KIND_DYNAMIC);
            free_cand = !probe_used;
         end
         ACT_REMOVE: begin
            hit = (probe_kind_ff == KIND_STATIC) && probe_ip_hit;
         end
         ACT_LOOKUP: begin
            hit = probe_used && probe_ip_hit;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   // track first match, highest free entry and oldest dynamic entry
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         have_match_ff <= 1'b0;
         have_free_ff  <= 1'b0;
         have_old_ff   <= 1'b0;
      end else if (probe_vld_ff) begin
         if (hit && !have_match_ff) begin
            have_match_ff <= 1'b1;
         end
         if (free_cand) begin
            have_free_ff <= 1'b1;
         end
         if (old_cand && (!have_old_ff || old_time_ff > probe_time)) begin
            have_old_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (probe_vld_ff) begin
         if (hit && !have_match_ff) begin
            match_idx_ff  <= probe_idx_ff;
            match_kind_ff <= probe_kind_ff;
            match_mac_ff  <= probe_mac;
            match_time_ff <= probe_time;
         end
         if (free_cand) begin
            free_idx_ff <= probe_idx_ff;
         end
         if (old_cand && (!have_old_ff || old_time_ff > probe_time)) begin
            old_idx_ff  <= probe_idx_ff;
            old_time_ff <= probe_time;
         end
      end
   end

   // decide: pick the entry to write, check freshness, form the result
   assign age   = now_ff - match_time_ff;
   assign fresh = (match_kind_ff == KIND_STATIC) || (age <= period_ff);

   always_comb begin
      res_status = STS_INVALID;
      res_mac    = '0;
      kind_we    = 1'b0;
      kind_widx  = match_idx_ff;
      kind_wval  = KIND_UNUSED;
      row_we     = 1'b0;
      row_widx   = match_idx_ff;
      case (op_ff)
         ACT_ADD: begin
            kind_wval = kind_req_ff;
            if (ip_ff == '0) begin
               res_status = STS_INVALID;
            end else if (have_match_ff || have_free_ff || have_old_ff) begin
               res_status = STS_OK;
               kind_we    = cmd.decide;
               row_we     = cmd.decide;
               if (have_match_ff) begin
                  kind_widx = match_idx_ff;
               end else if (have_free_ff) begin
                  kind_widx = free_idx_ff;
               end else begin
                  kind_widx = old_idx_ff;
               end
               row_widx = kind_widx;
            end else begin
               res_status = STS_FULL;
            end
         end
         ACT_REMOVE: begin
            if (have_match_ff) begin
               res_status = STS_OK;
               kind_we    = cmd.decide;
            end else begin
               res_status = STS_INVALID;
            end
         end
         ACT_LOOKUP: begin
            if (have_match_ff && fresh) begin
               res_status = STS_OK;
               res_mac    = match_mac_ff;
            end else begin
               res_status = STS_MISS;
               kind_we    = cmd.decide && have_match_ff;
            end
         end
         default: begin
            res_status = STS_INVALID;
         end
      endcase
   end

   // result register: load on decide, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.decide) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_status_ff <= res_status;
         rsp_mac_ff    <= res_mac;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_mac       = rsp_mac_ff;
   assign sts.down      = (op_ff == ACT_LOOKUP);
   assign sts.out_ready = !rsp_valid_ff || rsp_ready;

endmodule

// ----- hdl/arp_cache_table_core.sv -----
// Channel   Direction  tdata                        tuser
// req_      in         ip[31:0] mac[79:32]          action[1:0] make_static[2]
//                      now[111:80]
// rsp_      out        found_mac[47:0]              status[1:0]
// csr_      in         validity period (32 bits)    -
//
// An item goes through these steps in order: taking the transfer, one table read
// per entry through the single RAM read port, a drain of the read pipeline, and a
// decide that writes the table back.
// A new item is taken as soon as the decide cycle has passed, even while the
// previous result still waits in the output register.
// A stall on rsp_tready holds the decide cycle until the output register frees.
// Reset marks every entry unused at once and sets the period to 60000 ms.
`include "assert_macros.svh"

module arp_cache_table_core
   import act_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // ip_address, new_mac, now_ms
   input  logic [2:0]   req_tuser,   // action, make_static
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // found_mac
   output logic [1:0]   rsp_tuser,   // status
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   act_cmd_type cmd;
   act_sts_type sts;

   act_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   act_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_tuser[1:0]),
      .req_make_static (req_tuser[2]),
      .req_ip          (req_tdata[IP_W-1:0]),
      .req_mac         (req_tdata[IP_W+MAC_W-1:IP_W]),
      .req_now         (req_tdata[ROW_W-1:IP_W+MAC_W]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_mac         (rsp_tdata)
   );

   // one item at a time: no new transfer right after one is taken
   `ACT_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // the result register is never overwritten while it still holds a result
   `ACT_ASSERT_IMP(a_decide_free, clock, reset, cmd.decide, sts.out_ready)
   // the table is never scanned while the block takes a new item
   `ACT_ASSERT_IMP(a_scan_busy, clock, reset, cmd.scan, !req_tready)
   // only a hit carries a MAC address
   `ACT_ASSERT_IMP(a_mac_on_hit, clock, reset, rsp_tvalid && rsp_tuser != STS_OK, rsp_tdata == '0)

endmodule

// ----- bench/act_checker.sv -----
`timescale 1ns / 1ps

module act_checker
   import act_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,   // ip_address, new_mac, now_ms
   input  logic [2:0]   req_tuser,   // action, make_static
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,   // found_mac
   input  logic [1:0]   rsp_tuser,   // status
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   output int           fail_count,
   output int           open_count
);

   typedef struct packed {
      logic [1:0]       status;
      logic [MAC_W-1:0] mac;
   } answer_type;

   // shadow copy of the table and the period register
   logic [1:0]        tbl_kind [ENTRY_COUNT];
   logic [IP_W-1:0]   tbl_ip   [ENTRY_COUNT];
   logic [MAC_W-1:0]  tbl_mac  [ENTRY_COUNT];
   logic [TIME_W-1:0] tbl_time [ENTRY_COUNT];
   logic [TIME_W-1:0] period_ms;

   answer_type answer_q [$];
   int         mismatches;

   // apply one request to the shadow table and return the response it yields
   function automatic answer_type apply_table_op(input logic [1:0] act, input logic st,
                                                 input logic [IP_W-1:0] ip,
                                                 input logic [MAC_W-1:0] mac,
                                                 input logic [TIME_W-1:0] now);
      answer_type        res;
      logic [1:0]        kind;
      logic              hit, free, old_ok, done;
      int                i, hit_idx, free_idx, old_idx, pick;
      logic [TIME_W-1:0] age;
      res.status = STS_INVALID;
      res.mac    = '0;
      kind       = st ? KIND_STATIC : KIND_DYNAMIC;
      hit        = 1'b0;
      free       = 1'b0;
      old_ok     = 1'b0;
      done       = 1'b0;
      hit_idx    = 0;
      free_idx   = 0;
      old_idx    = 0;
      pick       = -1;
      case (act)
         ACT_ADD: begin
            if (ip != '0) begin
               // scan upward: stop on a match, track the top free slot and the oldest dynamic
               for (i = 0; i < ENTRY_COUNT && !hit; i++) begin
                  if (tbl_kind[i] != KIND_UNUSED) begin
                     if (tbl_ip[i] == ip &&
                         (tbl_kind[i] == kind || tbl_kind[i] == KIND_DYNAMIC)) begin
                        hit     = 1'b1;
                        hit_idx = i;
                     end else if (tbl_kind[i] == KIND_DYNAMIC &&
                                  (!old_ok || tbl_time[old_idx] > tbl_time[i])) begin
                        old_ok  = 1'b1;
                        old_idx = i;
                     end
                  end else begin
                     free     = 1'b1;
                     free_idx = i;
                  end
               end
               if (hit)
                  pick = hit_idx;
               else if (free)
                  pick = free_idx;
               else if (old_ok)
                  pick = old_idx;
               if (pick < 0) begin
                  res.status = STS_FULL;
               end else begin
                  tbl_kind[pick] = kind;
                  tbl_ip[pick]   = ip;
                  tbl_mac[pick]  = mac;
                  tbl_time[pick] = now;
                  res.status     = STS_OK;
               end
            end
         end
         ACT_REMOVE: begin
            // clear the first static slot holding this address
            for (i = 0; i < ENTRY_COUNT && !done; i++) begin
               if (tbl_kind[i] == KIND_STATIC && tbl_ip[i] == ip) begin
                  tbl_kind[i] = KIND_UNUSED;
                  tbl_ip[i]   = '0;
                  tbl_mac[i]  = '0;
                  tbl_time[i] = '0;
                  res.status  = STS_OK;
                  done        = 1'b1;
               end
            end
         end
         ACT_LOOKUP: begin
            // scan downward to the first used slot with this address
            res.status = STS_MISS;
            for (i = ENTRY_COUNT - 1; i >= 0 && !done; i--) begin
               if (tbl_kind[i] != KIND_UNUSED && tbl_ip[i] == ip) begin
                  done = 1'b1;
                  age  = now - tbl_time[i];
                  if (tbl_kind[i] == KIND_STATIC || age <= period_ms) begin
                     res.status = STS_OK;
                     res.mac    = tbl_mac[i];
                  end else begin
                     // stale: drop the kind only, keep the rest
                     tbl_kind[i] = KIND_UNUSED;
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            tbl_kind[i] = KIND_UNUSED;
            tbl_ip[i]   = '0;
            tbl_mac[i]  = '0;
            tbl_time[i] = '0;
         end
         period_ms = PERIOD_RESET;
         answer_q.delete();
         mismatches = 0;
      end else begin
         if (csr_wr_en)
            period_ms = csr_wr_data;

         // compare each result transfer with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("act_checker: unexpected result status=%0d mac=%012h",
                           rsp_tuser, rsp_tdata);
            end else begin
               want = answer_q.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata !== want.mac) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display(
                        "act_checker: mismatch status exp=%0d got=%0d mac exp=%012h got=%012h",
                        want.status, rsp_tuser, want.mac, rsp_tdata);
               end
            end
         end

         // predict each request transfer
         if (req_tvalid && req_tready)
            answer_q.push_back(apply_table_op(req_tuser[1:0], req_tuser[2],
                                              req_tdata[31:0], req_tdata[79:32],
                                              req_tdata[111:80]));
      end
      fail_count <= mismatches;
      open_count <= answer_q.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import act_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int LIMIT_NS  = 2_000_000;
   localparam int POOL_SIZE = 12;
   localparam int PHASES    = 6;
   localparam int PHASE_LEN = 300;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;   // ip_address, new_mac, now_ms
   logic [2:0]   req_tuser;   // action, make_static
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;   // found_mac
   logic [1:0]   rsp_tuser;   // status
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;
   int           fail_count;
   int           open_count;
   logic         steady;

   logic [31:0]  ip_pool [POOL_SIZE];
   logic [31:0]  now_ms;

   arp_cache_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   act_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .open_count  (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // stall the result side at random unless in a steady stretch
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= steady || ($urandom_range(0, 99) >= 32);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("tb_top: done, errors");
      $finish;
   end

   // present one request and hold it until the transfer
   task automatic send_req(input logic [1:0] act, input logic st, input logic [31:0] ip,
                           input logic [47:0] mac, input logic [31:0] now);
      if (!steady) begin
         while ($urandom_range(0, 99) < 32) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tdata  <= {now, mac, ip};
      req_tuser  <= {st, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   task automatic write_period(input logic [31:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // one random request: mostly addresses from a small pool so entries collide
   task automatic send_random(input int step_max);
      logic [63:0] wide;
      logic [31:0] ip;
      logic [1:0]  act;
      int          r;
      wide = {$urandom, $urandom};
      r    = $urandom_range(0, 99);
      if (r < 85)
         ip = ip_pool[4'($urandom_range(0, POOL_SIZE - 1))];
      else if (r < 95)
         ip = $urandom;
      else
         ip = '0;
      r = $urandom_range(0, 99);
      if (r < 40)
         act = ACT_ADD;
      else if (r < 75)
         act = ACT_LOOKUP;
      else if (r < 95)
         act = ACT_REMOVE;
      else
         act = ACT_UNUSED;
      if ($urandom_range(0, 99) < 3)
         now_ms = $urandom;
      else
         now_ms = now_ms + $urandom_range(0, step_max);
      send_req(act, 1'($urandom_range(0, 1)), ip, wide[47:0], now_ms);
   endtask

   initial begin
      logic [31:0] periods [PHASES];
      int          steps   [PHASES];
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      steady      = 1'b0;
      reset       = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edge addresses, every action, eviction, full table, expiry
      send_req(ACT_LOOKUP, 1'b0, 32'd1, 48'd0, 32'd100);
      send_req(ACT_ADD, 1'b1, 32'd0, 48'h1234_5678_9abc, 32'd100);
      send_req(ACT_UNUSED, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_req(ACT_ADD, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd100);
      send_req(ACT_LOOKUP, 1'b0, 32'hFFFF_FFFF, 48'd0, 32'd101);
      send_req(ACT_ADD, 1'b0, 32'hFFFF_FFFF, 48'd0, 32'd102);
      send_req(ACT_LOOKUP, 1'b1, 32'hFFFF_FFFF, 48'd0, 32'd102);
      send_req(ACT_REMOVE, 1'b0, 32'hFFFF_FFFF, 48'd0, 32'd103);
      send_req(ACT_REMOVE, 1'b0, 32'hFFFF_FFFF, 48'd0, 32'd104);
      for (int i = 2; i <= 8; i++)
         send_req(ACT_ADD, 1'b1, i, 48'h0000_0000_0100 + i, 32'd200 + i);
      send_req(ACT_ADD, 1'b1, 32'd9, 48'h0000_0000_0109, 32'd300);
      send_req(ACT_ADD, 1'b1, 32'd10, 48'h0000_0000_010a, 32'd301);
      send_req(ACT_LOOKUP, 1'b0, 32'd9, 48'd0, 32'h8000_0000);
      send_req(ACT_REMOVE, 1'b1, 32'd3, 48'd0, 32'd400);
      send_req(ACT_ADD, 1'b0, 32'd11, 48'h0000_0000_010b, 32'd1000);
      send_req(ACT_LOOKUP, 1'b0, 32'd11, 48'd0, 32'd61001);
      send_req(ACT_LOOKUP, 1'b0, 32'd11, 48'd0, 32'd61002);
      send_req(ACT_ADD, 1'b0, 32'd12, 48'h8000_0000_0001, 32'hFFFF_FFF0);
      send_req(ACT_LOOKUP, 1'b0, 32'd12, 48'd0, 32'hFFFF_FFF0 + 32'd60000);

      // random phases, each under its own validity period
      periods[0] = 32'd0;          steps[0] = 3;
      periods[1] = 32'hFFFF_FFFF;  steps[1] = 200000;
      periods[2] = 32'd40;         steps[2] = 15;
      periods[3] = 32'd1000;       steps[3] = 300;
      periods[4] = $urandom;       steps[4] = 100000;
      periods[5] = PERIOD_RESET;   steps[5] = 20000;
      for (int p = 0; p < PHASES; p++) begin
         write_period(periods[p]);
         for (int k = 0; k < POOL_SIZE; k++) begin
            ip_pool[k] = $urandom;
            if (ip_pool[k] == '0)
               ip_pool[k] = 32'd1;
         end
         now_ms = (p == 3) ? 32'hFFFF_F000 : $urandom;
         steady = (p == 2);
         for (int n = 0; n < PHASE_LEN; n++)
            send_random(steps[p]);
         steady = 1'b0;
      end

      // let the last results out, then give the verdict
      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
